// ----- src/tlad_pkg.sv -----
// Shared types and constants for the task load accounting block.
package tlad_pkg;

  // Field widths fixed by the item format
  localparam int ID_W   = 16;
  localparam int TICK_W = 16;
  localparam int CNT_W  = 32;

  // Default configuration
  localparam int          SLOTS_DEF = 32;
  localparam logic [31:0] TC_RESET  = 32'd200;

  // Action codes carried in in_tuser
  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_BIND    = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_QUERY   = 2'd3
  } tlad_act_t;

  // Result status carried in out_tuser
  localparam logic STAT_OK       = 1'b0;
  localparam logic STAT_NOTFOUND = 1'b1;

  // One slot table entry
  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   id;
    logic [CNT_W-1:0]  ticks;
  } tlad_entry_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QMUL,
    ST_QPROD,
    ST_MOD,
    ST_LOOK,
    ST_TOTAL,
    ST_WALK,
    ST_DONE
  } tlad_state_t;

endpackage

// ----- src/tlad_ram.sv -----
// Generic simple dual-port RAM with registered read.
module tlad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- src/task_load_accounting_with_decay.sv -----
// Top level of the task load accounting block with halving decay.
//
// Keeps one table entry per slot (task id modulo SLOTS) in a RAM, plus a running
// tick total. Items are taken one at a time: in_tready is high only while the
// sequencer is idle. The slot index comes from a reciprocal multiply, a constant
// multiply and one correcting subtract, then the slot is read from the RAM; this
// sequence sets the cost. A tick also passes through ST_TOTAL, which bind, release
// and query skip. A tick that pushes the total above time_constant adds a decay
// walk over all slots through the RAM read port, accumulating the halved counters
// with the same adder that serves the tick path. After reset a clearing pass
// writes every entry before the first item is taken; configuration writes are
// taken throughout. A finished result waits in the output register while the
// next item is accepted.
module task_load_accounting_with_decay
  import tlad_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // task_id [15:0], tick_count [31:16]
  input  logic [1:0]  in_tuser,   // action [1:0]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // total_ticks [31:0], task_ticks [63:32]
  output logic [0:0]  out_tuser,  // status [0]
  // configuration
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  localparam int AW  = $clog2(SLOTS);
  localparam int CW  = $clog2(SLOTS + 1);
  localparam int EW  = $bits(tlad_entry_t);
  localparam logic [31:0]     RECIP    = 32'((64'd1 << 32) / SLOTS);
  localparam logic [ID_W-1:0] SLOTS_ID = ID_W'(SLOTS);
  localparam logic [CW-1:0]   SLOTS_CW = CW'(SLOTS);
  localparam logic [CW-1:0]   LAST_CW  = CW'(SLOTS - 1);

  tlad_state_t state_r, state_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  tlad_act_t         act_r, act_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [TICK_W-1:0] tk_r, tk_nxt;
  logic [ID_W-1:0]   q_r, q_nxt;
  logic [ID_W-1:0]   prod_r, prod_nxt;
  logic [AW-1:0]     slot_r, slot_nxt;
  logic              hit_r, hit_nxt;
  logic [CNT_W-1:0]  upd_r, upd_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic [CNT_W-1:0]  tc_r;
  logic              status_r, status_nxt;
  logic [CNT_W-1:0]  task_r, task_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     wb_addr_r, wb_addr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_status_r, out_status_nxt;
  logic [CNT_W-1:0]  out_total_r, out_total_nxt;
  logic [CNT_W-1:0]  out_task_r, out_task_nxt;

  // RAM port signals
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  tlad_entry_t   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;
  tlad_entry_t   rd_ent;

  // Shared adder
  logic [CNT_W-1:0] add_a, add_b, add_y;

  // Slot index datapath
  logic [47:0]      qmul_full;
  logic [31:0]      pmul_full;
  logic [ID_W-1:0]  mod_diff, mod_fix;
  logic [CNT_W-1:0] halved;
  logic             look_hit;

  assign rd_ent    = tlad_entry_t'(ram_rdata);
  assign add_y     = add_a + add_b;
  assign qmul_full = 48'(id_r) * 48'(RECIP);
  assign pmul_full = 32'(q_r) * 32'(SLOTS);
  assign mod_diff  = id_r - prod_r;
  assign mod_fix   = (mod_diff >= SLOTS_ID) ? (mod_diff - SLOTS_ID) : mod_diff;
  assign halved    = rd_ent.ticks >> 1;
  assign look_hit  = rd_ent.valid && (rd_ent.id == id_r);

  tlad_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Hold the time constant register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r <= TC_RESET;
    end else if (cfg_wr_en) begin
      tc_r <= cfg_wr_data;
    end
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      idx_r       <= '0;
      total_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      total_r     <= total_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold payload registers
  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    id_r         <= id_nxt;
    tk_r         <= tk_nxt;
    q_r          <= q_nxt;
    prod_r       <= prod_nxt;
    slot_r       <= slot_nxt;
    hit_r        <= hit_nxt;
    upd_r        <= upd_nxt;
    status_r     <= status_nxt;
    task_r       <= task_nxt;
    wb_addr_r    <= wb_addr_nxt;
    out_status_r <= out_status_nxt;
    out_total_r  <= out_total_nxt;
    out_task_r   <= out_task_nxt;
  end

  // Sequence one item through the shared datapath
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    act_nxt        = act_r;
    id_nxt         = id_r;
    tk_nxt         = tk_r;
    q_nxt          = q_r;
    prod_nxt       = prod_r;
    slot_nxt       = slot_r;
    hit_nxt        = hit_r;
    upd_nxt        = upd_r;
    total_nxt      = total_r;
    status_nxt     = status_r;
    task_nxt       = task_r;
    pend_nxt       = pend_r;
    wb_addr_nxt    = wb_addr_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_total_nxt  = out_total_r;
    out_task_nxt   = out_task_r;
    in_tready      = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = slot_r;
    ram_wdata      = '0;
    ram_raddr      = '0;
    add_a          = total_r;
    add_b          = {{(CNT_W-TICK_W){1'b0}}, tk_r};

    // Drop the result once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[AW-1:0];
        idx_nxt   = idx_r + 1'b1;
        if (idx_r == LAST_CW) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          act_nxt   = tlad_act_t'(in_tuser);
          id_nxt    = in_tdata[15:0];
          tk_nxt    = in_tdata[31:16];
          state_nxt = ST_QMUL;
        end
      end

      // Estimate the quotient by the slot count
      ST_QMUL: begin
        q_nxt     = qmul_full[47:32];
        state_nxt = ST_QPROD;
      end

      ST_QPROD: begin
        prod_nxt  = pmul_full[ID_W-1:0];
        state_nxt = ST_MOD;
      end

      // Correct the remainder and read the slot
      ST_MOD: begin
        slot_nxt  = mod_fix[AW-1:0];
        ram_raddr = mod_fix[AW-1:0];
        state_nxt = ST_LOOK;
      end

      ST_LOOK: begin
        hit_nxt    = look_hit;
        status_nxt = STAT_NOTFOUND;
        task_nxt   = '0;
        state_nxt  = ST_DONE;
        unique case (act_r)
          ACT_TICK: begin
            add_a     = rd_ent.ticks;
            upd_nxt   = add_y;
            state_nxt = ST_TOTAL;
          end
          ACT_BIND: begin
            ram_we          = 1'b1;
            ram_wdata.valid = 1'b1;
            ram_wdata.id    = id_r;
            status_nxt      = STAT_OK;
          end
          ACT_RELEASE: begin
            if (look_hit) begin
              ram_we          = 1'b1;
              ram_wdata       = rd_ent;
              ram_wdata.valid = 1'b0;
              status_nxt      = STAT_OK;
              task_nxt        = rd_ent.ticks;
            end
          end
          ACT_QUERY: begin
            if (look_hit) begin
              status_nxt = STAT_OK;
              task_nxt   = rd_ent.ticks;
            end
          end
          default: ;
        endcase
      end

      // Charge the total, store the counter and check for decay
      ST_TOTAL: begin
        ram_we          = hit_r;
        ram_wdata.valid = 1'b1;
        ram_wdata.id    = id_r;
        ram_wdata.ticks = upd_r;
        status_nxt      = hit_r ? STAT_OK : STAT_NOTFOUND;
        if (add_y > tc_r) begin
          task_nxt  = hit_r ? (upd_r >> 1) : '0;
          total_nxt = '0;
          idx_nxt   = '0;
          pend_nxt  = 1'b0;
          state_nxt = ST_WALK;
        end else begin
          task_nxt  = hit_r ? upd_r : '0;
          total_nxt = add_y;
          state_nxt = ST_DONE;
        end
      end

      // Halve every valid counter and rebuild the total
      ST_WALK: begin
        if (idx_r < SLOTS_CW) begin
          ram_raddr   = idx_r[AW-1:0];
          wb_addr_nxt = idx_r[AW-1:0];
          idx_nxt     = idx_r + 1'b1;
          pend_nxt    = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r && rd_ent.valid) begin
          ram_we          = 1'b1;
          ram_waddr       = wb_addr_r;
          ram_wdata       = rd_ent;
          ram_wdata.ticks = halved;
          add_b           = halved;
          total_nxt       = add_y;
        end
        if (!pend_r && idx_r == SLOTS_CW) begin
          state_nxt = ST_DONE;
        end
      end

      // Load the result once the output register is free
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_total_nxt  = total_r;
          out_task_nxt   = task_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_task_r, out_total_r};
  assign out_tuser  = out_status_r;

endmodule

// ----- src/tlad_chk.sv -----
// Port-level checker for the task load accounting block, bound to the top level.
module tlad_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [0:0]  out_tuser
);

  // Reset leaves the block busy clearing and with no result pending
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("block not quiet after reset");

  // An accepted item keeps the block busy in the next cycle
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again right after a transfer");

  // A not-found result carries a zero task count
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[63:32] == 32'd0)
    else $error("not-found result with nonzero task count");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind task_load_accounting_with_decay tlad_chk u_tlad_chk (.*);

// ----- tb/sv/tb_task_load_accounting_with_decay.sv -----
// Self-checking testbench for the task load accounting block with halving decay.
`timescale 1ns / 1ps

module tb_task_load_accounting_with_decay;
  import tlad_pkg::*;

  localparam int QUIET_LIMIT  = 2000;  // cycles with no transfer before giving up
  localparam int HOLD_LEN     = 100;   // long receiver hold-off
  localparam int DRAIN_CYCLES = 40;
  localparam int POOL_N       = 10;

  // One predicted result item
  typedef struct {
    logic        status;
    logic [31:0] total;
    logic [31:0] task_cnt;
  } load_result_t;

  // Load table predictor plus the queue of results it still waits for
  class load_scoreboard;
    logic         slot_used [SLOTS_DEF];
    logic [15:0]  slot_owner[SLOTS_DEF];
    logic [31:0]  slot_count[SLOTS_DEF];
    logic [31:0]  total;
    logic [31:0]  decay_limit;
    load_result_t pending_q[$];
    int           errors;
    int           results;
    int           decays;
    int           by_action[4];

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      total       = '0;
      decay_limit = TC_RESET;
      errors      = 0;
      results     = 0;
      decays      = 0;
      foreach (by_action[i]) by_action[i] = 0;
    endfunction

    // Advance the table by one accepted item and queue its result
    function void note_input(tlad_act_t act, logic [15:0] id, logic [15:0] tk);
      int unsigned  s;
      logic         hit;
      logic [31:0]  sum;
      load_result_t r;
      s = id % SLOTS_DEF;
      hit = slot_used[s] && (slot_owner[s] == id);
      r.status   = STAT_NOTFOUND;
      r.task_cnt = '0;
      by_action[act]++;
      case (act)
        ACT_TICK: begin
          if (hit) slot_count[s] += 32'(tk);
          total += 32'(tk);
          // halve every live counter and rebuild the total from them
          if (total > decay_limit) begin
            sum = '0;
            for (int i = 0; i < SLOTS_DEF; i++) begin
              if (slot_used[i]) begin
                slot_count[i] = slot_count[i] >> 1;
                sum += slot_count[i];
              end
            end
            total = sum;
            decays++;
          end
          if (hit) begin
            r.status   = STAT_OK;
            r.task_cnt = slot_count[s];
          end
        end
        ACT_BIND: begin
          slot_used[s]  = 1'b1;
          slot_owner[s] = id;
          slot_count[s] = '0;
          r.status      = STAT_OK;
        end
        ACT_RELEASE: begin
          if (hit) begin
            r.status     = STAT_OK;
            r.task_cnt   = slot_count[s];
            slot_used[s] = 1'b0;
          end
        end
        default: begin
          if (hit) begin
            r.status   = STAT_OK;
            r.task_cnt = slot_count[s];
          end
        end
      endcase
      r.total = total;
      pending_q.push_back(r);
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    // Compare one result transfer with the oldest prediction
    task check_result(logic st, logic [31:0] tot, logic [31:0] cnt);
      load_result_t e;
      results++;
      if (pending_q.size() == 0) begin
        report($sformatf("unrequested result: status %0d total %0d task %0d", st, tot, cnt));
        return;
      end
      e = pending_q.pop_front();
      if (st !== e.status)
        report($sformatf("status got %0d, want %0d", st, e.status));
      if (tot !== e.total)
        report($sformatf("total_ticks got %0d, want %0d", tot, e.total));
      if (cnt !== e.task_cnt)
        report($sformatf("task_ticks got %0d, want %0d", cnt, e.task_cnt));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // task_id [15:0], tick_count [31:16]
  logic [1:0]  in_tuser;   // action [1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // total_ticks [31:0], task_ticks [63:32]
  logic [0:0]  out_tuser;  // status [0]
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;

  bit          tx_idle;
  bit          rx_idle;
  bit          hold_req;
  int          quiet;
  logic [15:0] id_pool[POOL_N];

  load_scoreboard sb = new();

  task_load_accounting_with_decay #(
    .SLOTS(SLOTS_DEF)
  ) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // 8 ns clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_LEN;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (rx_idle && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        stall_left = $urandom_range(0, 5);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Check result transfers and watch for a hung block
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        sb.check_result(out_tuser[0], out_tdata[31:0], out_tdata[63:32]);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  // Offer one item, with an optional gap first; return after its transfer
  task automatic send_item(input tlad_act_t act, input logic [15:0] id, input logic [15:0] tk);
    int gap;
    if (tx_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {tk, id};
    do @(posedge clk); while (!in_tready);
    sb.note_input(act, id, tk);
  endtask

  // Drain all pending results, then write the time constant
  task automatic write_time_constant(input logic [31:0] v);
    in_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en      <= 1'b0;
    sb.decay_limit = v;
  endtask

  // Random item: mostly pool ids that collide in a few slots, some noise ids
  task automatic send_random();
    int          r;
    int          rt;
    tlad_act_t   act;
    logic [15:0] id;
    logic [15:0] tk;
    r = $urandom_range(0, 99);
    if (r < 45)      act = ACT_TICK;
    else if (r < 60) act = ACT_BIND;
    else if (r < 72) act = ACT_RELEASE;
    else             act = ACT_QUERY;
    if ($urandom_range(0, 4) == 0) id = 16'($urandom());
    else id = id_pool[$urandom_range(0, POOL_N - 1)];
    rt = $urandom_range(0, 99);
    if (rt < 10)      tk = 16'd0;
    else if (rt < 18) tk = 16'hFFFF;
    else if (rt < 60) tk = 16'($urandom_range(0, 255));
    else              tk = 16'($urandom());
    send_item(act, id, tk);
  endtask

  task automatic run_phase(input logic [31:0] tc, input int n, input bit idle_on,
                           input bit squeeze);
    int hi;
    int sl;
    write_time_constant(tc);
    tx_idle = idle_on;
    rx_idle = idle_on;
    // fresh id pool, ids drawn from six slots so that they collide
    for (int k = 0; k < POOL_N; k++) begin
      hi = $urandom_range(0, 2047);
      sl = $urandom_range(0, 5) * 5;
      id_pool[k] = {hi[10:0], sl[4:0]};
    end
    for (int i = 0; i < n; i++) begin
      if (squeeze && i == n / 2) hold_req = 1'b1;
      send_random();
    end
  endtask

  initial begin : main
    logic [31:0] tc_any;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = ACT_TICK;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    quiet       = 0;
    tx_idle     = 1'b1;
    rx_idle     = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty slots, foreign ids, rebinding, release, decay, extremes
    write_time_constant(32'd300);
    send_item(ACT_QUERY,   16'd0,     16'd0);
    send_item(ACT_TICK,    16'd0,     16'd5);
    send_item(ACT_BIND,    16'd0,     16'd0);
    send_item(ACT_TICK,    16'd0,     16'd10);
    send_item(ACT_QUERY,   16'd0,     16'd0);
    send_item(ACT_BIND,    16'd32,    16'd0);
    send_item(ACT_QUERY,   16'd0,     16'd0);
    send_item(ACT_RELEASE, 16'd0,     16'd0);
    send_item(ACT_TICK,    16'd32,    16'hFFFF);
    send_item(ACT_BIND,    16'hFFFF,  16'hFFFF);
    send_item(ACT_TICK,    16'hFFFF,  16'd0);
    send_item(ACT_TICK,    16'hFFFF,  16'd200);
    send_item(ACT_QUERY,   16'hFFFF,  16'hFFFF);
    send_item(ACT_RELEASE, 16'hFFFF,  16'd0);
    send_item(ACT_QUERY,   16'hFFFF,  16'd0);
    send_item(ACT_RELEASE, 16'hFFFF,  16'd0);
    send_item(ACT_BIND,    16'd1,     16'd0);
    send_item(ACT_BIND,    16'd2,     16'd0);
    send_item(ACT_TICK,    16'd1,     16'd100);
    send_item(ACT_TICK,    16'd2,     16'd100);
    send_item(ACT_TICK,    16'd1,     16'd200);
    write_time_constant(32'd1);
    send_item(ACT_TICK,    16'd2,     16'd1);
    send_item(ACT_TICK,    16'h5555,  16'd1);
    send_item(ACT_QUERY,   16'd2,     16'd0);

    // Random phases over a spread of time constants
    tc_any = $urandom();
    if (tc_any == 0) tc_any = 32'd1;
    run_phase(32'd1,                      250, 1'b1, 1'b0);
    run_phase(32'hFFFF_FFFF,              250, 1'b1, 1'b1);
    run_phase($urandom_range(500, 100000), 250, 1'b1, 1'b0);
    run_phase(tc_any,                     250, 1'b1, 1'b0);
    run_phase(TC_RESET,                   250, 1'b1, 1'b1);
    run_phase(32'd2000,                   350, 1'b0, 1'b0);

    // Let every result come back, then a quiet tail
    in_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d items: %0d ticks, %0d binds, %0d releases, %0d queries; %0d results.",
             sb.by_action[ACT_TICK] + sb.by_action[ACT_BIND] + sb.by_action[ACT_RELEASE]
             + sb.by_action[ACT_QUERY], sb.by_action[ACT_TICK], sb.by_action[ACT_BIND],
             sb.by_action[ACT_RELEASE], sb.by_action[ACT_QUERY], sb.results);
    $display("Decay walks: %0d; time constants from 1 to 2^32-1, with long output hold-offs.",
             sb.decays);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/tlad_pkg.sv
src/tlad_ram.sv
src/task_load_accounting_with_decay.sv
src/tlad_chk.sv
tb/sv/tb_task_load_accounting_with_decay.sv
